// File: rtl/plba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plba_pkg: shared types and constants for the price-level book aggregator
// Field widths, result status codes, level record and cell control bundle.
// ----------------------------------------------------------------------------
package plba_pkg;

	localparam int PRICE_W  = 32;
	localparam int SHARES_W = 32;
	localparam int ORDERS_W = 16;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 5;
	localparam int DEPTH_W  = 6;
	localparam int CFG_W    = 6;

	localparam logic [CFG_W-1:0] CFG_RESET = 6'd20;

	localparam logic [STATUS_W-1:0] ST_MERGE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INSERT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROP   = 2'd2;

	typedef struct packed {
		logic [PRICE_W-1:0]  price;
		logic [SHARES_W-1:0] shares;
		logic [ORDERS_W-1:0] orders;
	} level_t;

	// per-side control broadcast to every cell of a chain
	typedef struct packed {
		logic cap;     // capture compare flags for the incoming word
		logic upd;     // apply the update decided in the compare stage
		logic ins_ok;  // no match and the side has room
		logic ask;     // ascending order (ask side)
	} cell_ctl_t;

endpackage

// File: rtl/plba_order_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plba_order_if: order-add channel
// Valid/ready channel carrying side, price and share count of one added order.
// ----------------------------------------------------------------------------
interface plba_order_if import plba_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                side;
	logic [PRICE_W-1:0]  price;
	logic [SHARES_W-1:0] shares;

	modport source (output valid, output side, output price, output shares, input ready);
	modport sink (input valid, input side, input price, input shares, output ready);
endinterface

// File: rtl/plba_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plba_result_if: level update result channel
// Valid/ready channel carrying the outcome of one order add.
// ----------------------------------------------------------------------------
interface plba_result_if import plba_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    level_position;
	logic [SHARES_W-1:0] level_total_shares;
	logic [ORDERS_W-1:0] level_order_count;
	logic [DEPTH_W-1:0]  side_depth;

	modport source (output valid, output status, output level_position,
		output level_total_shares, output level_order_count, output side_depth,
		input ready);
	modport sink (input valid, input status, input level_position,
		input level_total_shares, input level_order_count, input side_depth,
		output ready);
endinterface

// File: rtl/price_level_book_aggregator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_book_aggregator: bid/ask price-level book for one instrument
// Merges order adds into sorted per-side level chains and reports the result.
// ----------------------------------------------------------------------------
// Usage:
//   order  : valid/ready word with side (0 bid, 1 ask), price and shares.
//   result : valid/ready word with status (merge / insert / drop), rank of
//            the level from best price, level totals and the side depth.
//   cfg_we / cfg_wdata : writes max_levels (levels kept per side, reset 20);
//            write only while no word is in flight.
//   Each side is a chain of MAX_LEVELS cells. On acceptance every cell of
//   that side compares the price with its level; when the word leaves the
//   compare stage the cells merge, insert or shift one place down toward
//   the worst price. The result is registered in the output register as the
//   cells update. A new word is taken only once the previous one has left
//   the compare stage.
//   Reset: both sides empty, max_levels 20, no result pending.
//   Stall: a result waits in the output register; the next word is taken
//   and compared meanwhile, then holds in the compare stage until the
//   output register frees.
// ----------------------------------------------------------------------------
module price_level_book_aggregator import plba_pkg::*; #(
	parameter int MAX_LEVELS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	plba_order_if.sink        order,
	plba_result_if.source     result,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_LEVELS + 1);
	localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0]    max_levels_q;
	logic [CNT_W-1:0]    n_q [2];
	logic                s1_vld_q;
	logic                side_s1;
	logic [PRICE_W-1:0]  price_s1;
	logic [SHARES_W-1:0] shares_s1;

	logic                out_vld_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    pos_q;
	logic [SHARES_W-1:0] tot_q;
	logic [ORDERS_W-1:0] cnt_q;
	logic [DEPTH_W-1:0]  depth_q;

	logic                acc;
	logic                adv;
	logic                m_any;
	logic                ins_ok;
	logic [LW-1:0]       n_ext;
	logic [LW-1:0]       lim_ext;
	logic [CNT_W-1:0]    n_sel;
	logic [CNT_W-1:0]    pos_acc;
	logic [SHARES_W-1:0] sh_acc;
	logic [ORDERS_W-1:0] or_acc;
	logic [MAX_LEVELS-1:0] m_sel;
	logic [MAX_LEVELS-1:0] hit_sel;

	cell_ctl_t           ctl [2];
	level_t              lvl [2][MAX_LEVELS];
	logic [MAX_LEVELS-1:0] b_f [2];
	logic [MAX_LEVELS-1:0] m_f [2];
	logic [MAX_LEVELS-1:0] hit_f [2];
	logic [SHARES_W-1:0] sum_sh [2][MAX_LEVELS];
	logic [ORDERS_W-1:0] sum_or [2][MAX_LEVELS];

	assign order.ready = !s1_vld_q;
	assign acc = order.valid && order.ready;
	assign adv = s1_vld_q && (!out_vld_q || result.ready);

	// ---------------- cell chains ----------------
	for (genvar s = 0; s < 2; s++) begin : g_side
		assign ctl[s].cap    = acc && (order.side == 1'(s));
		assign ctl[s].upd    = adv && (side_s1 == 1'(s));
		assign ctl[s].ins_ok = ins_ok;
		assign ctl[s].ask    = 1'(s);

		for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
			level_t prev_lvl;
			logic   prev_b;
			logic   occ;

			assign occ = n_q[s] > CNT_W'(i);
			if (i == 0) begin : g_head
				assign prev_lvl = '0;
				assign prev_b   = 1'b0;
			end else begin : g_link
				assign prev_lvl = lvl[s][i-1];
				assign prev_b   = b_f[s][i-1];
			end

			plba_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[s]),
				.occ        (occ),
				.in_price   (acc ? order.price : price_s1),
				.in_shares  (shares_s1),
				.prev       (prev_lvl),
				.prev_b     (prev_b),
				.lvl        (lvl[s][i]),
				.b_flag     (b_f[s][i]),
				.m_flag     (m_f[s][i]),
				.hit        (hit_f[s][i]),
				.sum_shares (sum_sh[s][i]),
				.sum_orders (sum_or[s][i])
			);
		end
	end

	// ---------------- decision ----------------
	always_comb begin
		m_sel   = m_f[side_s1];
		hit_sel = hit_f[side_s1];
		m_any   = |m_sel;
		n_sel   = n_q[side_s1];
		n_ext   = LW'(n_sel);
		lim_ext = (LW'(max_levels_q) > LW'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(max_levels_q);
		ins_ok  = !m_any && (n_ext < lim_ext);
		pos_acc = '0;
		sh_acc  = '0;
		or_acc  = '0;
		for (int k = 0; k < MAX_LEVELS; k++) begin
			// on a merge the first ranking-behind cell also flags a hit
			if (m_any ? m_sel[k] : hit_sel[k])
				pos_acc = pos_acc | CNT_W'(k);
			if (m_sel[k]) begin
				sh_acc = sh_acc | sum_sh[side_s1][k];
				or_acc = or_acc | sum_or[side_s1][k];
			end
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_levels_q <= CFG_RESET;
			n_q[0]       <= '0;
			n_q[1]       <= '0;
			s1_vld_q     <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_we)
				max_levels_q <= cfg_wdata;
			if (acc)
				s1_vld_q <= 1'b1;
			else if (adv)
				s1_vld_q <= 1'b0;
			if (adv)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
			if (adv && ins_ok)
				n_q[side_s1] <= n_sel + CNT_W'(1);
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (acc) begin
			side_s1   <= order.side;
			price_s1  <= order.price;
			shares_s1 <= order.shares;
		end
		if (adv) begin
			if (m_any) begin
				status_q <= ST_MERGE;
				pos_q    <= POS_W'(pos_acc);
				tot_q    <= sh_acc;
				cnt_q    <= or_acc;
				depth_q  <= DEPTH_W'(n_sel);
			end else if (ins_ok) begin
				status_q <= ST_INSERT;
				pos_q    <= POS_W'(pos_acc);
				tot_q    <= shares_s1;
				cnt_q    <= ORDERS_W'(1);
				depth_q  <= DEPTH_W'(n_sel + CNT_W'(1));
			end else begin
				status_q <= ST_DROP;
				pos_q    <= '0;
				tot_q    <= '0;
				cnt_q    <= '0;
				depth_q  <= DEPTH_W'(n_sel);
			end
		end
	end

	assign result.valid              = out_vld_q;
	assign result.status             = status_q;
	assign result.level_position     = pos_q;
	assign result.level_total_shares = tot_q;
	assign result.level_order_count  = cnt_q;
	assign result.side_depth         = depth_q;

	// ---------------- assertions ----------------
	a_insert_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ins_ok |-> $onehot(hit_sel))
		else $error("insert point not unique");

	a_match_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> $onehot0(m_sel))
		else $error("price matched more than one level");

	a_depth_cap: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(n_q[0]) <= LW'(MAX_LEVELS) && LW'(n_q[1]) <= LW'(MAX_LEVELS))
		else $error("side depth above capacity");

	a_bid_grow: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ins_ok && !side_s1 |=> n_q[0] == $past(n_q[0]) + CNT_W'(1))
		else $error("bid depth not raised on insert");

endmodule

// File: rtl/plba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plba_cell: one price level of a sorted side chain
// Compares the incoming price against its level, then merges, takes the new
// level, takes its upper neighbor's level (shift) or holds.
// ----------------------------------------------------------------------------
module plba_cell import plba_pkg::*; (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic                occ,
	input  logic [PRICE_W-1:0]  in_price,
	input  logic [SHARES_W-1:0] in_shares,
	input  level_t              prev,
	input  logic                prev_b,
	output level_t              lvl,
	output logic                b_flag,
	output logic                m_flag,
	output logic                hit,
	output logic [SHARES_W-1:0] sum_shares,
	output logic [ORDERS_W-1:0] sum_orders
);

	logic [PRICE_W-1:0]  price_q;
	logic [SHARES_W-1:0] shares_q;
	logic [ORDERS_W-1:0] orders_q;
	logic                m_s1;
	logic                b_s1;
	logic                better;
	logic [SHARES_W:0]   sum_ext;

	// incoming price ranks ahead of this level; empty cells rank last
	assign better = ctl.ask ? (in_price < price_q) : (in_price > price_q);

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			m_s1 <= occ && (in_price == price_q);
			b_s1 <= !occ || better;
		end
	end

	assign sum_ext    = {1'b0, shares_q} + {1'b0, in_shares};
	assign sum_shares = sum_ext[SHARES_W] ? '1 : sum_ext[SHARES_W-1:0];
	assign sum_orders = (orders_q == '1) ? orders_q : orders_q + ORDERS_W'(1);

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			if (m_s1) begin
				shares_q <= sum_shares;
				orders_q <= sum_orders;
			end else if (ctl.ins_ok && b_s1) begin
				if (!prev_b) begin
					price_q  <= in_price;
					shares_q <= in_shares;
					orders_q <= ORDERS_W'(1);
				end else begin
					price_q  <= prev.price;
					shares_q <= prev.shares;
					orders_q <= prev.orders;
				end
			end
		end
	end

	assign lvl    = '{price: price_q, shares: shares_q, orders: orders_q};
	assign b_flag = b_s1;
	assign m_flag = m_s1;
	assign hit    = m_s1 || (b_s1 && !prev_b);

endmodule

// File: sim/price_level_book_aggregator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_book_aggregator_tb: self-checking bench for the level book
// Drives order-add words and checks every result word against the expected
// word of the script row or a software copy of both sides of the book. The
// run covers a directed script, a short merge run into one level, and random
// phases over several level limits and several idle and stall patterns.
// ----------------------------------------------------------------------------
module price_level_book_aggregator_tb;
	import plba_pkg::*;

	localparam int BOOK_DEPTH = 32;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 100;
	localparam int SAT_RUN = 40;
	localparam int HOLD_CYCLES = 150;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [SHARES_W-1:0] total;
		logic [ORDERS_W-1:0] count;
		logic [DEPTH_W-1:0]  depth;
	} level_result_t;

	typedef enum logic {ROW_ADD, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic                side;
		logic [PRICE_W-1:0]  price;
		logic [SHARES_W-1:0] shares;
		logic [CFG_W-1:0]    limit;
		logic                typed;
		level_result_t       want;
	} script_row_t;

	// bid side 0, ask side 1; rows with typed set carry their expected word
	localparam int SCRIPT_LEN = 25;
	localparam script_row_t BOOK_SCRIPT [SCRIPT_LEN] = '{
		'{ROW_ADD, 1'b0, 32'd100, 32'd10, 6'd0, 1'b1,
			'{ST_INSERT, 5'd0, 32'd10, 16'd1, 6'd1}},
		'{ROW_ADD, 1'b0, 32'd100, ALL_ONES, 6'd0, 1'b1,
			'{ST_MERGE, 5'd0, ALL_ONES, 16'd2, 6'd1}},
		'{ROW_ADD, 1'b0, 32'd100, 32'd5, 6'd0, 1'b1,
			'{ST_MERGE, 5'd0, ALL_ONES, 16'd3, 6'd1}},
		'{ROW_ADD, 1'b0, ALL_ONES, 32'd0, 6'd0, 1'b1,
			'{ST_INSERT, 5'd0, 32'd0, 16'd1, 6'd2}},
		'{ROW_ADD, 1'b0, 32'd0, 32'd7, 6'd0, 1'b1,
			'{ST_INSERT, 5'd2, 32'd7, 16'd1, 6'd3}},
		'{ROW_ADD, 1'b0, 32'd50, 32'd1, 6'd0, 1'b0, '0},
		'{ROW_ADD, 1'b1, 32'd0, 32'd0, 6'd0, 1'b1,
			'{ST_INSERT, 5'd0, 32'd0, 16'd1, 6'd1}},
		'{ROW_ADD, 1'b1, ALL_ONES, ALL_ONES, 6'd0, 1'b1,
			'{ST_INSERT, 5'd1, ALL_ONES, 16'd1, 6'd2}},
		'{ROW_ADD, 1'b1, 32'd1000, 32'd3, 6'd0, 1'b0, '0},
		'{ROW_ADD, 1'b1, 32'd0, 32'd1, 6'd0, 1'b0, '0},
		'{ROW_ADD, 1'b1, ALL_ONES, 32'd1, 6'd0, 1'b0, '0},
		'{ROW_ADD, 1'b1, 32'd500, 32'd2, 6'd0, 1'b0, '0},
		// limit below the depth already held
		'{ROW_LIMIT, 1'b0, 32'd0, 32'd0, 6'd3, 1'b0, '0},
		'{ROW_ADD, 1'b0, 32'd77, 32'd9, 6'd0, 1'b1,
			'{ST_DROP, 5'd0, 32'd0, 16'd0, 6'd4}},
		'{ROW_ADD, 1'b0, 32'd50, 32'd4, 6'd0, 1'b0, '0},
		'{ROW_ADD, 1'b1, 32'd2000, 32'd8, 6'd0, 1'b1,
			'{ST_DROP, 5'd0, 32'd0, 16'd0, 6'd4}},
		'{ROW_LIMIT, 1'b0, 32'd0, 32'd0, 6'd0, 1'b0, '0},
		'{ROW_ADD, 1'b0, 32'd1, 32'd1, 6'd0, 1'b1,
			'{ST_DROP, 5'd0, 32'd0, 16'd0, 6'd4}},
		'{ROW_ADD, 1'b1, 32'd500, 32'd1, 6'd0, 1'b0, '0},
		// above capacity acts as full capacity
		'{ROW_LIMIT, 1'b0, 32'd0, 32'd0, 6'd63, 1'b0, '0},
		'{ROW_ADD, 1'b0, 32'd60, 32'd6, 6'd0, 1'b0, '0},
		'{ROW_ADD, 1'b1, 32'd7, 32'hFFFF_FFFE, 6'd0, 1'b0, '0},
		'{ROW_LIMIT, 1'b0, 32'd0, 32'd0, 6'd1, 1'b0, '0},
		'{ROW_ADD, 1'b1, 32'd3, 32'd1, 6'd0, 1'b1,
			'{ST_DROP, 5'd0, 32'd0, 16'd0, 6'd5}},
		'{ROW_LIMIT, 1'b0, 32'd0, 32'd0, 6'd32, 1'b0, '0}
	};

	localparam logic [CFG_W-1:0] PHASE_LIMIT [RANDOM_PHASES] =
		'{6'd10, 6'd1, 6'd63, 6'd0, 6'd24, 6'd7, 6'd32, 6'd20};
	localparam int SEND_IDLE_PCT [4] = '{0, 72, 0, 16};
	localparam int RECV_STALL_PCT [4] = '{0, 0, 72, 16};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	plba_order_if  order_ch ();
	plba_result_if result_ch ();

	price_level_book_aggregator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// book copy, index [side][rank]
	logic [PRICE_W-1:0]  book_price  [2][BOOK_DEPTH];
	logic [SHARES_W-1:0] book_shares [2][BOOK_DEPTH];
	logic [ORDERS_W-1:0] book_orders [2][BOOK_DEPTH];
	int                  book_depth  [2];
	int                  level_limit;

	level_result_t pending_results [$];
	int  fail_count;
	int  quiet_cycles;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic level_result_t apply_order(logic side, logic [PRICE_W-1:0] price,
			logic [SHARES_W-1:0] shares);
		level_result_t r;
		int n, lim, at, i;
		logic [SHARES_W:0] sum;
		n = book_depth[side];
		lim = (level_limit > BOOK_DEPTH) ? BOOK_DEPTH : level_limit;
		for (i = 0; i < n; i++) begin
			if (book_price[side][i] == price) begin
				sum = {1'b0, book_shares[side][i]} + {1'b0, shares};
				book_shares[side][i] = sum[SHARES_W] ? ALL_ONES : sum[SHARES_W-1:0];
				if (book_orders[side][i] != 16'hFFFF)
					book_orders[side][i] = book_orders[side][i] + 16'd1;
				r.status = ST_MERGE;
				r.position = POS_W'(i);
				r.total = book_shares[side][i];
				r.count = book_orders[side][i];
				r.depth = DEPTH_W'(n);
				return r;
			end
		end
		if (n >= lim) begin
			r = '0;
			r.status = ST_DROP;
			r.depth = DEPTH_W'(n);
			return r;
		end
		// bids rank by descending price, asks by ascending
		at = n;
		for (i = 0; i < n; i++) begin
			if (side ? (price < book_price[side][i]) : (price > book_price[side][i])) begin
				at = i;
				break;
			end
		end
		for (i = n; i > at; i--) begin
			book_price[side][i] = book_price[side][i-1];
			book_shares[side][i] = book_shares[side][i-1];
			book_orders[side][i] = book_orders[side][i-1];
		end
		book_price[side][at] = price;
		book_shares[side][at] = shares;
		book_orders[side][at] = 16'd1;
		book_depth[side] = n + 1;
		r.status = ST_INSERT;
		r.position = POS_W'(at);
		r.total = shares;
		r.count = 16'd1;
		r.depth = DEPTH_W'(n + 1);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
	endtask

	// one word per call; valid stays high into the next call when no gap is rolled
	task automatic send_order(logic side, logic [PRICE_W-1:0] price,
			logic [SHARES_W-1:0] shares, logic typed, level_result_t typed_want);
		level_result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			order_ch.valid <= 1'b0;
			@(negedge clk);
		end
		order_ch.valid <= 1'b1;
		order_ch.side <= side;
		order_ch.price <= price;
		order_ch.shares <= shares;
		@(posedge clk);
		while (!order_ch.ready)
			@(posedge clk);
		predicted = apply_order(side, price, shares);
		pending_results.push_back(typed ? typed_want : predicted);
	endtask

	task automatic write_limit(logic [CFG_W-1:0] value);
		@(negedge clk);
		order_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		level_limit = int'(value);
	endtask

	// receiver: random stalls, plus one long hold-off counted here
	initial begin
		int hold_left;
		hold_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		level_result_t got, want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got.status = result_ch.status;
			got.position = result_ch.level_position;
			got.total = result_ch.level_total_shares;
			got.count = result_ch.level_order_count;
			got.depth = result_ch.side_depth;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, total", got.total, '0);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.position !== want.position)
					report_mismatch("level_position", 32'(got.position),
						32'(want.position));
				if (got.total !== want.total)
					report_mismatch("level_total_shares", got.total, want.total);
				if (got.count !== want.count)
					report_mismatch("level_order_count", 32'(got.count), 32'(want.count));
				if (got.depth !== want.depth)
					report_mismatch("side_depth", 32'(got.depth), 32'(want.depth));
			end
		end
	end

	// watchdog: cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((order_ch.valid === 1'b1 && order_ch.ready === 1'b1) ||
				(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int ph, k, r;
		logic side;
		logic [PRICE_W-1:0] price;
		logic [SHARES_W-1:0] shares;
		logic [CFG_W-1:0] limit;
		script_row_t row;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		order_ch.valid = 1'b0;
		order_ch.side = 1'b0;
		order_ch.price = '0;
		order_ch.shares = '0;
		fail_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b0;
		book_depth[0] = 0;
		book_depth[1] = 0;
		level_limit = int'(CFG_RESET);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < SCRIPT_LEN; k++) begin
			row = BOOK_SCRIPT[k];
			if (row.kind == ROW_LIMIT)
				write_limit(row.limit);
			else
				send_order(row.side, row.price, row.shares, row.typed, row.want);
		end

		// repeated merges into the ask level at price 0
		for (k = 0; k < SAT_RUN; k++)
			send_order(1'b1, 32'd0, 32'($urandom_range(0, 3)), 1'b0, '0);

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			limit = (ph == RANDOM_PHASES - 1) ? CFG_W'($urandom_range(0, 63)) : PHASE_LIMIT[ph];
			write_limit(limit);
			send_idle_pct = SEND_IDLE_PCT[ph % 4];
			recv_stall_pct = RECV_STALL_PCT[ph % 4];
			if (ph == 4)
				hold_request = 1'b1;
			for (k = 0; k < WORDS_PER_PHASE; k++) begin
				side = 1'($urandom_range(0, 1));
				r = $urandom_range(0, 99);
				// mostly prices already on the book or in a narrow band
				if (r < 45 && book_depth[side] > 0)
					price = book_price[side][$urandom_range(0, book_depth[side] - 1)];
				else if (r < 70)
					price = 32'd900 + 32'($urandom_range(0, 200));
				else if (r < 80)
					case ($urandom_range(0, 3))
						0: price = 32'd0;
						1: price = ALL_ONES;
						2: price = 32'd1;
						default: price = 32'hFFFF_FFFE;
					endcase
				else
					price = $urandom;
				r = $urandom_range(0, 99);
				if (r < 60)
					shares = 32'($urandom_range(0, 5000));
				else if (r < 75)
					shares = $urandom;
				else if (r < 85)
					shares = 32'd0;
				else if (r < 95)
					shares = ALL_ONES;
				else
					shares = ALL_ONES - 32'($urandom_range(0, 10));
				send_order(side, price, shares, 1'b0, '0);
			end
		end

		@(negedge clk);
		order_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/plba_pkg.sv
rtl/plba_order_if.sv
rtl/plba_result_if.sv
rtl/plba_cell.sv
rtl/price_level_book_aggregator.sv
sim/price_level_book_aggregator_tb.sv
